// ===== src/mahb_pkg.sv =====
// ============================================================================
// mahb_pkg
// Shared types and constants of the multi-axis histogram binning unit.
// ============================================================================
package mahb_pkg;

	// Store geometry
	localparam int BIN_DEPTH = 65536;
	localparam int ADDR_W    = $clog2(BIN_DEPTH);
	localparam int STORE_W   = 64;               // {hit count, photon sum}

	// Field widths
	localparam int INDEX_W   = 24;
	localparam int SIZE_W    = 17;
	localparam int REL_W     = 17;
	localparam int LIN1_W    = REL_W + SIZE_W;   // slow * size1 + middle
	localparam int LIN_W     = LIN1_W + SIZE_W;  // full three-axis address
	localparam int BINA_W    = 16;               // bin_address / read_address
	localparam int SUM_W     = 32;
	localparam int DATA_W    = 32;               // APB data
	localparam int PADDR_W   = 5;

	// Request codes
	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// axis_count value selecting two axes; any other value means three
	localparam logic [1:0] AXES_TWO = 2'd2;

	typedef enum logic [2:0] {
		REG_AXIS_COUNT = 3'd0,
		REG_AXIS0_MIN  = 3'd1,
		REG_AXIS1_MIN  = 3'd2,
		REG_AXIS2_MIN  = 3'd3,
		REG_AXIS0_SIZE = 3'd4,
		REG_AXIS1_SIZE = 3'd5,
		REG_AXIS2_SIZE = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]                    axis_count;
		logic [2:0][INDEX_W-1:0]       axis_lo;
		logic [2:0][SIZE_W-1:0]        axis_bins;
	} cfg_t;

endpackage

// ===== src/mahb_ram.sv =====
// ============================================================================
// mahb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module mahb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/mahb_regs.sv =====
// ============================================================================
// mahb_regs
// APB register file holding the axis configuration.
// ============================================================================
module mahb_regs import mahb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_count <= 2'd3;
			cfg_q.axis_lo    <= '0;
			cfg_q.axis_bins  <= {3{SIZE_W'(1)}};
		end else if (wr_en) begin
			case (idx)
				REG_AXIS_COUNT: cfg_q.axis_count   <= pwdata[1:0];
				REG_AXIS0_MIN:  cfg_q.axis_lo[0]   <= pwdata[INDEX_W-1:0];
				REG_AXIS1_MIN:  cfg_q.axis_lo[1]   <= pwdata[INDEX_W-1:0];
				REG_AXIS2_MIN:  cfg_q.axis_lo[2]   <= pwdata[INDEX_W-1:0];
				REG_AXIS0_SIZE: cfg_q.axis_bins[0] <= pwdata[SIZE_W-1:0];
				REG_AXIS1_SIZE: cfg_q.axis_bins[1] <= pwdata[SIZE_W-1:0];
				REG_AXIS2_SIZE: cfg_q.axis_bins[2] <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// minima read back sign-extended
	always_comb begin
		case (idx)
			REG_AXIS_COUNT: prdata = DATA_W'(cfg_q.axis_count);
			REG_AXIS0_MIN:  prdata = DATA_W'($signed(cfg_q.axis_lo[0]));
			REG_AXIS1_MIN:  prdata = DATA_W'($signed(cfg_q.axis_lo[1]));
			REG_AXIS2_MIN:  prdata = DATA_W'($signed(cfg_q.axis_lo[2]));
			REG_AXIS0_SIZE: prdata = DATA_W'(cfg_q.axis_bins[0]);
			REG_AXIS1_SIZE: prdata = DATA_W'(cfg_q.axis_bins[1]);
			REG_AXIS2_SIZE: prdata = DATA_W'(cfg_q.axis_bins[2]);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== src/multi_axis_histogram_binning_unit.sv =====
// ============================================================================
// multi_axis_histogram_binning_unit
// Bins signed multi-axis indexes into a row-major histogram store.
//
// Input channel (in_valid / in_stall): one word per request. An add request
// (req_type 0) turns index0..index2 into a linear bin address relative to the
// axis minima, adds intensity to the photon sum and one to the hit count of
// that bin. A read request (req_type 1) returns both sums of read_address.
// Output channel (out_valid / out_stall): one word per request, carrying the
// bin address and the sums after the update. Items outside an axis or beyond
// the store come back with accepted low and all other fields zero.
// Sequence: an add passes the offset step, the two multiply steps of the
// address, the store read and the update; a read skips the multiply steps.
// One request is in flight at a time, since each runs the read-modify-write
// sequence over the single read port of the store.
// The output word sits in a register, so a new request is taken while the
// previous result waits; a stalled result holds and blocks only the final
// write-back step of the next request.
// Reset: the store is zeroed by a sweep over all 65536 bins, one bin per cycle;
// in_stall stays high during it. APB writes are taken at any time.
// ============================================================================
module multi_axis_histogram_binning_unit import mahb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	// request channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  logic signed [INDEX_W-1:0] index0,
	input  logic signed [INDEX_W-1:0] index1,
	input  logic signed [INDEX_W-1:0] index2,
	input  logic signed [SUM_W-1:0]   intensity,
	input  logic [BINA_W-1:0]         read_address,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      accepted,
	output logic [BINA_W-1:0]         bin_address,
	output logic [SUM_W-1:0]          photon_sum,
	output logic [SUM_W-1:0]          hit_count
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_OFFSET,
		S_MUL1,
		S_MUL2,
		S_READ,
		S_UPDATE
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BIN_DEPTH - 1);

	cfg_t cfg;

	// sequencer and result register
	state_t              state_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic                out_valid_q;
	logic                accepted_q;
	logic [BINA_W-1:0]   bin_address_q;
	logic [SUM_W-1:0]    photon_q;
	logic [SUM_W-1:0]    count_q;

	// request held while it runs
	logic                    req_q;
	logic [2:0][INDEX_W-1:0] idx_q;
	logic [SUM_W-1:0]        intensity_q;
	logic [BINA_W-1:0]       raddr_q;
	logic [2:0][REL_W-1:0]   rel_q;
	logic                    ok_q;
	logic [LIN_W-1:0]        lin_q;

	logic [2:0][REL_W:0] chk;     // {in range, relative index} per axis
	logic                three;
	logic                all_ok;
	logic [LIN1_W-1:0]   prod1;
	logic [LIN_W-1:0]    prod2;
	logic                lin_in_range;
	logic                out_free;
	logic [SUM_W-1:0]    new_photon;
	logic [SUM_W-1:0]    new_count;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [STORE_W-1:0]  ram_wdata;
	logic                ram_re;
	logic [STORE_W-1:0]  ram_rdata;

	// Offset along one axis: index minus minimum, kept only if 0 <= d < size
	function automatic logic [REL_W:0] axis_rel(input logic [INDEX_W-1:0] idx,
	                                            input logic [INDEX_W-1:0] lo,
	                                            input logic [SIZE_W-1:0]  size);
		logic signed [INDEX_W:0] d;
		logic                    in_axis;
		d       = $signed({idx[INDEX_W-1], idx}) - $signed({lo[INDEX_W-1], lo});
		in_axis = !d[INDEX_W] && (d[INDEX_W-1:0] < INDEX_W'(size));
		return {in_axis, d[REL_W-1:0]};
	endfunction

	mahb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Combined store: upper half hit count, lower half photon sum
	mahb_ram #(
		.WIDTH (STORE_W),
		.DEPTH (BIN_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (lin_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// Address arithmetic
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			chk[a] = axis_rel(idx_q[a], cfg.axis_lo[a], cfg.axis_bins[a]);
		end
	end

	assign three  = (cfg.axis_count != AXES_TWO);
	assign all_ok = chk[0][REL_W] && chk[1][REL_W] && (!three || chk[2][REL_W]);

	assign prod1 = LIN1_W'(rel_q[0]) * LIN1_W'(cfg.axis_bins[1]) + LIN1_W'(rel_q[1]);
	assign prod2 = LIN_W'(lin_q[LIN1_W-1:0]) * LIN_W'(cfg.axis_bins[2])
	             + LIN_W'(rel_q[2]);

	assign lin_in_range = (lin_q < LIN_W'(BIN_DEPTH));

	// Update of the word read back from the store
	assign new_photon = ram_rdata[SUM_W-1:0] + intensity_q;
	assign new_count  = ram_rdata[STORE_W-1:SUM_W] + SUM_W'(1);

	assign out_free = !out_valid_q || !out_stall;

	// Store access: zero sweep after reset, else write-back of an add
	assign ram_we    = (state_q == S_CLEAR) ||
	                   ((state_q == S_UPDATE) && out_free && (req_q == REQ_ADD) && ok_q);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_addr_q : lin_q[ADDR_W-1:0];
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : {new_count, new_photon};
	assign ram_re    = (state_q == S_READ);

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign bin_address = bin_address_q;
	assign photon_sum  = photon_q;
	assign hit_count   = count_q;

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_addr_q    <= '0;
			out_valid_q   <= 1'b0;
			accepted_q    <= 1'b0;
			bin_address_q <= '0;
			photon_q      <= '0;
			count_q       <= '0;
		end else begin
			// the update step reloads the result word itself
			if (out_valid_q && !out_stall && (state_q != S_UPDATE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_OFFSET;
					end
				end
				S_OFFSET: state_q <= (req_q == REQ_READ) ? S_READ : S_MUL1;
				S_MUL1:   state_q <= S_MUL2;
				S_MUL2:   state_q <= S_READ;
				S_READ:   state_q <= S_UPDATE;
				S_UPDATE: begin
					if (out_free) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						accepted_q  <= ok_q;
						if (req_q == REQ_READ) begin
							bin_address_q <= raddr_q;
							photon_q      <= ok_q ? ram_rdata[SUM_W-1:0] : '0;
							count_q       <= ok_q ? ram_rdata[STORE_W-1:SUM_W] : '0;
						end else begin
							bin_address_q <= ok_q ? BINA_W'(lin_q) : '0;
							photon_q      <= ok_q ? new_photon : '0;
							count_q       <= ok_q ? new_count : '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q       <= req_type;
				idx_q[0]    <= index0;
				idx_q[1]    <= index1;
				idx_q[2]    <= index2;
				intensity_q <= intensity;
				raddr_q     <= read_address;
			end
			S_OFFSET: begin
				if (req_q == REQ_READ) begin
					lin_q <= LIN_W'(raddr_q);
					ok_q  <= 1'b1;
				end else begin
					for (int a = 0; a < 3; a++) begin
						rel_q[a] <= chk[a][REL_W-1:0];
					end
					ok_q <= all_ok;
				end
			end
			S_MUL1: lin_q <= LIN_W'(prod1);
			S_MUL2: begin
				if (three) begin
					lin_q <= prod2;
				end
			end
			S_READ: ok_q <= ok_q && lin_in_range;
			default: ;
		endcase
	end

endmodule

// ===== src/mahb_checker.sv =====
// ============================================================================
// mahb_checker
// Port-level assertions for the histogram binning unit, bound to the top.
// ============================================================================
module mahb_checker import mahb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              accepted,
	input logic [BINA_W-1:0] bin_address,
	input logic [SUM_W-1:0]  photon_sum,
	input logic [SUM_W-1:0]  hit_count
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(accepted) &&
		$stable(bin_address) && $stable(photon_sum) && $stable(hit_count))
		else $error("result word changed while stalled");

	// one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while one is in flight");

	// a new result only comes out of a busy unit
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in flight");

	// refused requests carry no sums
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> photon_sum == '0 && hit_count == '0)
		else $error("refused request returned nonzero sums");

endmodule

bind multi_axis_histogram_binning_unit mahb_checker u_mahb_checker (.*);

// ===== verif/multi_axis_histogram_binning_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram binning unit testbench
// Drives add and read words into the binning unit under random idling on both
// channels and checks every result word against a local model of the axes and
// the two bin stores. A short table of directed words comes first, then
// random words over several axis settings written through the APB port.
// ----------------------------------------------------------------------------
module multi_axis_histogram_binning_unit_test;
	import mahb_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 12;     // longer than one add request
	localparam int N_PHASES    = 9;

	typedef struct packed {
		logic                   req_type;
		logic [INDEX_W-1:0]     index0;
		logic [INDEX_W-1:0]     index1;
		logic [INDEX_W-1:0]     index2;
		logic [SUM_W-1:0]       intensity;
		logic [BINA_W-1:0]      read_address;
	} bin_req_t;

	typedef struct packed {
		logic                   accepted;
		logic [BINA_W-1:0]      bin_address;
		logic [SUM_W-1:0]       photon_sum;
		logic [SUM_W-1:0]       hit_count;
	} bin_result_t;

	typedef struct packed {
		bin_req_t               stim;
		bit                     typed;   // want holds a hand-written result
		bin_result_t            want;
	} dir_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [PADDR_W-1:0]        paddr;
	logic [DATA_W-1:0]         pwdata;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;
	logic                      in_valid;
	logic                      in_stall;
	logic                      req_type;
	logic signed [INDEX_W-1:0] index0;
	logic signed [INDEX_W-1:0] index1;
	logic signed [INDEX_W-1:0] index2;
	logic signed [SUM_W-1:0]   intensity;
	logic [BINA_W-1:0]         read_address;
	logic                      out_valid;
	logic                      out_stall;
	logic                      accepted;
	logic [BINA_W-1:0]         bin_address;
	logic [SUM_W-1:0]          photon_sum;
	logic [SUM_W-1:0]          hit_count;

	// Local copy of the bin stores and the axis registers
	bit [SUM_W-1:0]  photon_mem [BIN_DEPTH];
	bit [SUM_W-1:0]  count_mem  [BIN_DEPTH];
	cfg_t            axis_cfg;
	bit [BINA_W-1:0] touched_q [$];   // bins hit so far, read targets

	bin_result_t     result_q [$];    // expected result words, oldest first
	dir_row_t        dir_tab [$];
	cfg_t            phase_cfg [N_PHASES];
	int              phase_len [N_PHASES];

	int              fail_count;
	int              cycle_count;
	bit              quiet_tail;      // no idling on either side once set

	multi_axis_histogram_binning_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.index0       (index0),
		.index1       (index1),
		.index2       (index2),
		.intensity    (intensity),
		.read_address (read_address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accepted     (accepted),
		.bin_address  (bin_address),
		.photon_sum   (photon_sum),
		.hit_count    (hit_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Bin model: computes the result word of one request and updates the stores
	// ------------------------------------------------------------------------
	function automatic bin_result_t bin_update(input bin_req_t w);
		bin_result_t                res;
		logic signed [INDEX_W-1:0]  ix [3];
		longint                     rel [3];
		longint                     d;
		longint                     lin;
		bit                         in_cube;
		bit                         three;
		int                         a;
		res = '0;
		if (w.req_type == REQ_READ) begin
			// read_address is 16 bits, always inside the store
			res.accepted    = 1'b1;
			res.bin_address = w.read_address;
			res.photon_sum  = photon_mem[w.read_address];
			res.hit_count   = count_mem[w.read_address];
			return res;
		end
		ix[0]   = w.index0;
		ix[1]   = w.index1;
		ix[2]   = w.index2;
		three   = (axis_cfg.axis_count != AXES_TWO);
		in_cube = 1'b1;
		for (int i = 0; i < 3; i++) begin
			d = longint'(ix[i]) - longint'($signed(axis_cfg.axis_lo[i]));
			rel[i] = d;
			// axis 2 only counts in three-axis mode
			if ((i < 2 || three) && (d < 0 || d >= longint'(axis_cfg.axis_bins[i])))
				in_cube = 1'b0;
		end
		if (!in_cube)
			return res;
		lin = rel[0] * longint'(axis_cfg.axis_bins[1]) + rel[1];
		if (three)
			lin = lin * longint'(axis_cfg.axis_bins[2]) + rel[2];
		if (lin >= BIN_DEPTH)
			return res;
		a = int'(lin);
		photon_mem[a]   = photon_mem[a] + w.intensity;
		count_mem[a]    = count_mem[a] + 1;
		res.accepted    = 1'b1;
		res.bin_address = BINA_W'(a);
		res.photon_sum  = photon_mem[a];
		res.hit_count   = count_mem[a];
		touched_q.push_back(BINA_W'(a));
		return res;
	endfunction

	// Relative index: mostly the first few bins so sums pile up
	function automatic logic [INDEX_W-1:0] pick_rel(input logic [SIZE_W-1:0] sz);
		int top;
		if (sz == 0)
			return '0;
		top = (sz > 4) ? 3 : int'(sz) - 1;
		if ($urandom_range(0, 3) == 0)
			top = int'(sz) - 1;
		return INDEX_W'($urandom_range(0, top));
	endfunction

	function automatic bin_req_t make_word();
		bin_req_t           w;
		logic [INDEX_W-1:0] v [3];
		int                 sel;
		w.req_type     = REQ_ADD;
		w.index0       = INDEX_W'($urandom);
		w.index1       = INDEX_W'($urandom);
		w.index2       = INDEX_W'($urandom);
		w.intensity    = $urandom;
		w.read_address = BINA_W'($urandom);
		if ($urandom_range(0, 4) == 0) begin
			w.req_type = REQ_READ;
			if (touched_q.size() != 0 && $urandom_range(0, 3) != 0)
				w.read_address = touched_q[$urandom_range(0, touched_q.size() - 1)];
			return w;
		end
		for (int i = 0; i < 3; i++) begin
			sel = $urandom_range(0, 31);
			if (sel == 0)
				v[i] = INDEX_W'($urandom);                   // anywhere
			else if (sel == 1)
				v[i] = axis_cfg.axis_lo[i] - 1'b1;           // just below
			else if (sel == 2)
				v[i] = axis_cfg.axis_lo[i] + INDEX_W'(axis_cfg.axis_bins[i]); // one past
			else
				v[i] = axis_cfg.axis_lo[i] + pick_rel(axis_cfg.axis_bins[i]);
		end
		w.index0 = v[0];
		w.index1 = v[1];
		// with two axes index2 is don't-care: leave it random half the time
		if (!(axis_cfg.axis_count == AXES_TWO && $urandom_range(0, 1) == 0))
			w.index2 = v[2];
		sel = $urandom_range(0, 15);
		case (sel)
			0:       w.intensity = 32'h8000_0000;
			1:       w.intensity = 32'h7FFF_FFFF;
			2:       w.intensity = 32'hFFFF_FFFF;
			3, 4, 5: w.intensity = SUM_W'($urandom_range(0, 100));
			default: ;
		endcase
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------
	task automatic idle_in(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Present one word, hold it until taken, then log its expected result.
	task automatic push_word(input bin_req_t w, input bit typed, input bin_result_t want);
		bin_result_t got;
		@(negedge clk);
		in_valid     <= 1'b1;
		req_type     <= w.req_type;
		index0       <= w.index0;
		index1       <= w.index1;
		index2       <= w.index2;
		intensity    <= w.intensity;
		read_address <= w.read_address;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		got = bin_update(w);
		result_q.push_back(typed ? want : got);
	endtask

	// Wait for every result, then let a trailing write-back finish
	task automatic drain();
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write: setup cycle, access cycle
	task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		case (idx)
			REG_AXIS_COUNT: axis_cfg.axis_count   = val[1:0];
			REG_AXIS0_MIN:  axis_cfg.axis_lo[0]   = val[INDEX_W-1:0];
			REG_AXIS1_MIN:  axis_cfg.axis_lo[1]   = val[INDEX_W-1:0];
			REG_AXIS2_MIN:  axis_cfg.axis_lo[2]   = val[INDEX_W-1:0];
			REG_AXIS0_SIZE: axis_cfg.axis_bins[0] = val[SIZE_W-1:0];
			REG_AXIS1_SIZE: axis_cfg.axis_bins[1] = val[SIZE_W-1:0];
			REG_AXIS2_SIZE: axis_cfg.axis_bins[2] = val[SIZE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Minima go out sign-extended; the unit keeps the low 24 bits
	task automatic write_axes(input cfg_t c);
		reg_write(REG_AXIS_COUNT, DATA_W'(c.axis_count));
		reg_write(REG_AXIS0_MIN,  DATA_W'($signed(c.axis_lo[0])));
		reg_write(REG_AXIS1_MIN,  DATA_W'($signed(c.axis_lo[1])));
		reg_write(REG_AXIS2_MIN,  DATA_W'($signed(c.axis_lo[2])));
		reg_write(REG_AXIS0_SIZE, DATA_W'(c.axis_bins[0]));
		reg_write(REG_AXIS1_SIZE, DATA_W'(c.axis_bins[1]));
		reg_write(REG_AXIS2_SIZE, DATA_W'(c.axis_bins[2]));
	endtask

	task automatic tab_row(input logic rt, input logic [INDEX_W-1:0] i0, i1, i2,
			input logic [SUM_W-1:0] inten, input logic [BINA_W-1:0] ra, input bit typed,
			input logic acc, input logic [BINA_W-1:0] ba, input logic [SUM_W-1:0] ps, hc);
		dir_row_t r;
		r.stim  = {rt, i0, i1, i2, inten, ra};
		r.typed = typed;
		r.want  = {acc, ba, ps, hc};
		dir_tab.push_back(r);
	endtask

	task automatic set_phase(input int p, input logic [1:0] ac, input int m0, m1, m2,
			input int s0, s1, s2, input int n);
		phase_cfg[p].axis_count   = ac;
		phase_cfg[p].axis_lo[0]   = INDEX_W'(m0);
		phase_cfg[p].axis_lo[1]   = INDEX_W'(m1);
		phase_cfg[p].axis_lo[2]   = INDEX_W'(m2);
		phase_cfg[p].axis_bins[0] = SIZE_W'(s0);
		phase_cfg[p].axis_bins[1] = SIZE_W'(s1);
		phase_cfg[p].axis_bins[2] = SIZE_W'(s2);
		phase_len[p] = n;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		bin_req_t w;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		req_type     = REQ_ADD;
		index0       = '0;
		index1       = '0;
		index2       = '0;
		intensity    = '0;
		read_address = '0;
		quiet_tail   = 1'b0;
		fail_count   = 0;

		// register values after reset: three axes, minima 0, sizes 1
		axis_cfg.axis_count = 2'd3;
		axis_cfg.axis_lo    = '0;
		axis_cfg.axis_bins  = {SIZE_W'(1), SIZE_W'(1), SIZE_W'(1)};

		// Directed words under the reset axes: only bin (0,0,0) exists.
		//       type      index0        index1        index2        intensity
		//       read addr  typed acc  bin addr     photon sum    hit count
		tab_row(REQ_READ, 24'h000000, 24'h000000, 24'h000000, 32'h0000_0000,
			16'h0000, 1'b1, 1'b1, 16'h0000, 32'h0000_0000, 32'd0);  // cleared store
		tab_row(REQ_READ, 24'h000000, 24'h000000, 24'h000000, 32'h0000_0000,
			16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 32'h0000_0000, 32'd0);  // top bin
		tab_row(REQ_ADD,  24'h000000, 24'h000000, 24'h000000, 32'h0000_0005,
			16'h0000, 1'b1, 1'b1, 16'h0000, 32'h0000_0005, 32'd1);
		tab_row(REQ_ADD,  24'h000000, 24'h000000, 24'h000000, 32'hFFFF_FFFF,
			16'h0000, 1'b1, 1'b1, 16'h0000, 32'h0000_0004, 32'd2);  // minus one
		tab_row(REQ_ADD,  24'h000000, 24'h000000, 24'h000000, 32'h7FFF_FFFF,
			16'h0000, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 32'd0);
		tab_row(REQ_ADD,  24'h000000, 24'h000000, 24'h000000, 32'h8000_0000,
			16'h0000, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 32'd0);  // sum wraps
		tab_row(REQ_ADD,  24'h000001, 24'h000000, 24'h000000, 32'h0000_0009,
			16'h0000, 1'b1, 1'b0, 16'h0000, 32'h0000_0000, 32'd0);  // at axis size
		tab_row(REQ_ADD,  24'hFFFFFF, 24'h000000, 24'h000000, 32'h0000_0009,
			16'h0000, 1'b1, 1'b0, 16'h0000, 32'h0000_0000, 32'd0);  // below minimum
		tab_row(REQ_ADD,  24'h000000, 24'h7FFFFF, 24'h000000, 32'h0000_0009,
			16'h0000, 1'b1, 1'b0, 16'h0000, 32'h0000_0000, 32'd0);
		tab_row(REQ_ADD,  24'h000000, 24'h000000, 24'h800000, 32'h0000_0009,
			16'h0000, 1'b1, 1'b0, 16'h0000, 32'h0000_0000, 32'd0);
		tab_row(REQ_ADD,  24'h800000, 24'h7FFFFF, 24'hFFFFFF, 32'h0000_0000,
			16'h0000, 1'b1, 1'b0, 16'h0000, 32'h0000_0000, 32'd0);
		tab_row(REQ_ADD,  24'h000000, 24'h000000, 24'h000000, 32'h0000_0000,
			16'h0000, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 32'd0);  // zero intensity
		tab_row(REQ_READ, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF,
			16'h0000, 1'b0, 1'b0, 16'h0000, 32'h0000_0000, 32'd0);
		tab_row(REQ_READ, 24'h000000, 24'h000000, 24'h000000, 32'h0000_0000,
			16'h5555, 1'b1, 1'b1, 16'h5555, 32'h0000_0000, 32'd0);
		tab_row(REQ_READ, 24'h000000, 24'h000000, 24'h000000, 32'h0000_0000,
			16'hAAAA, 1'b1, 1'b1, 16'hAAAA, 32'h0000_0000, 32'd0);

		// Axis settings for the random part; axis_count 0 and 1 also mean three
		//           axes  min0      min1      min2      size0  size1  size2  words
		set_phase(0, 2'd2, 0,        0,        0,        16,    16,    1,     260);
		set_phase(1, 2'd3, -5,       100,      -8388608, 4,     8,     8,     260);
		set_phase(2, 2'd1, -8388608, 8388607,  0,        65536, 65536, 65536, 150);
		set_phase(3, 2'd2, -8388608, 8388607,  -1,       65536, 1,     3,     200);
		set_phase(4, 2'd0, 0,        0,        0,        0,     4,     4,     60);  // empty axis
		set_phase(5, 2'd3, 1000,     -1000,    0,        40,    40,    41,    250); // overruns store
		set_phase(6, 2'd3, 0,        0,        0,        64,    32,    32,    250); // fills store
		set_phase(7, 2'd2, -3,       7,        8388607,  256,   256,   1,     250);
		set_phase(8, 2'd3, 8388605,  -8388608, 0,        2,     3,     5,     300);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first word waits out the store-clearing sweep behind in_stall
		foreach (dir_tab[i])
			push_word(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
		idle_in(1);
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			if (p == N_PHASES - 1)
				quiet_tail = 1'b1;
			write_axes(phase_cfg[p]);
			for (int k = 0; k < phase_len[p]; k++) begin
				// halfway through, hold off until the pipe is empty
				if (k == phase_len[p] / 2) begin
					idle_in(1);
					drain();
				end
				// gap bursts, with a calm stretch every 128 words
				if (!quiet_tail && (k % 128) < 96 && $urandom_range(0, 4) == 0)
					idle_in($urandom_range(1, 19));
				w = make_word();
				push_word(w, 1'b0, '0);
			end
			idle_in(1);
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && result_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: random stall bursts between runs of open cycles
	// ------------------------------------------------------------------------
	initial begin : stall_gen
		int n;
		out_stall = 1'b0;
		forever begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 30);
			repeat (n) begin
				@(negedge clk);
				out_stall <= 1'b0;
			end
			if (!quiet_tail) begin
				n = $urandom_range(1, 19);
				repeat (n) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		bin_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (result_q.size() == 0) begin
				$error("result word with none pending, bin_address 0x%0h", bin_address);
				fail_count++;
			end else begin
				want = result_q.pop_front();
				check_field("accepted",    SUM_W'(want.accepted),    SUM_W'(accepted));
				check_field("bin_address", SUM_W'(want.bin_address), SUM_W'(bin_address));
				check_field("photon_sum",  want.photon_sum,          photon_sum);
				check_field("hit_count",   want.hit_count,           hit_count);
			end
		end
	end

	// Watchdog: covers the clearing sweep plus a slow run, several times
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule
